### rtl/cgfb_pkg.sv
package cgfb_pkg;

    localparam int MAX_GRID_COLS_DEF = 64;
    localparam int MAX_GRID_ROWS_DEF = 64;
    localparam int MAX_PER_CELL_DEF  = 16;
    localparam int MAX_RESULTS       = 16;

    localparam int OP_W     = 2;
    localparam int POS_W    = 16;
    localparam int ID_W     = 10;
    localparam int STATUS_W = 3;
    localparam int CW_OUT_W = 8;
    localparam int SIZE_W   = 9;
    localparam int WIN_W    = 4;
    localparam int GRID_W   = 7;
    localparam int GDIM_W   = 9;
    localparam int REG_IDX_W = 3;
    localparam int REG_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVEN_WIN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_COL  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_ROW  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_COLS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_ROWS = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GRID_COLS   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS   = 3'd7;

endpackage

### rtl/coarse_grid_feature_binning_core.sv
// Steps: insert and lookup divide the offset from the origin in a shared-step divider; an
//   insert then read-modify-writes the count memory per window cell, a lookup reads the count
//   and one entry per listed id, a clear sweeps the count memory; unknown operations give no result.
// Throughput: one transaction at a time; the next is taken once the last result is queued.
// Reset: control and configuration registers take their reset values at once; a sweep of one
//   count entry per cycle then empties the grid before the first transaction.
module coarse_grid_feature_binning_core #(
    parameter int MAX_GRID_COLS = cgfb_pkg::MAX_GRID_COLS_DEF,
    parameter int MAX_GRID_ROWS = cgfb_pkg::MAX_GRID_ROWS_DEF,
    parameter int MAX_PER_CELL  = cgfb_pkg::MAX_PER_CELL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cgfb_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [cgfb_pkg::REG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cgfb_pkg::OP_W-1:0]         operation,
    input  logic signed [cgfb_pkg::POS_W-1:0] pos_col,
    input  logic signed [cgfb_pkg::POS_W-1:0] pos_row,
    input  logic [cgfb_pkg::ID_W-1:0]         feature_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cgfb_pkg::STATUS_W-1:0]     status,
    output logic [cgfb_pkg::ID_W-1:0]         found_id,
    output logic [cgfb_pkg::CW_OUT_W-1:0]     cells_written,
    output logic                              last
);
    import cgfb_pkg::*;

    localparam int NCELLS  = MAX_GRID_COLS * MAX_GRID_ROWS;
    localparam int CELL_AW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int NENT    = NCELLS * MAX_PER_CELL;
    localparam int ENT_AW  = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int CNT_W   = $clog2(MAX_PER_CELL + 1);
    localparam int QW      = POS_W + 1;
    localparam int DCW     = $clog2(QW + 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_CLEAR   = 11'b00000000010,
        S_DIV     = 11'b00000000100,
        S_SETUP   = 11'b00000001000,
        S_INS_RD  = 11'b00000010000,
        S_INS_WR  = 11'b00000100000,
        S_LK_ADR  = 11'b00001000000,
        S_LK_CNT  = 11'b00010000000,
        S_LK_RD   = 11'b00100000000,
        S_LK_DATA = 11'b01000000000,
        S_EMIT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [POS_W-1:0] origin_col_reg, origin_row_reg;
    logic [SIZE_W-1:0] cell_width_reg, cell_height_reg;
    logic [WIN_W-1:0]  window_cols_reg, window_rows_reg;
    logic [GRID_W-1:0] grid_cols_reg, grid_rows_reg;

    logic [CELL_AW-1:0] sweep_reg, sweep_next;
    logic clr_emit_reg, clr_emit_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic neg_c_reg, neg_c_next, neg_r_reg, neg_r_next;
    logic [QW-1:0] qc_reg, qc_next, qr_reg, qr_next;
    logic [SIZE_W-1:0] remc_reg, remc_next, remr_reg, remr_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic [GDIM_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [GDIM_W-1:0] cs_reg, cs_next, ce_reg, ce_next, re_reg, re_next;
    logic [CNT_W-1:0] k_reg, k_next, n_reg, n_next;
    logic full_reg, full_next;
    logic [CW_OUT_W-1:0] written_reg, written_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0] res_id_reg, res_id_next;
    logic [CW_OUT_W-1:0] res_cw_reg, res_cw_next;
    logic res_last_reg, res_last_next;
    logic out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic [CW_OUT_W-1:0] out_cw_reg, out_cw_next;
    logic out_last_reg, out_last_next;

    logic cnt_we, ent_we;
    logic [CELL_AW-1:0] cnt_waddr, cell_idx;
    logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
    logic [ENT_AW-1:0] ent_waddr, ent_raddr;
    logic [ID_W-1:0] ent_rdata;

    logic [SIZE_W-1:0] div_c, div_r;
    logic [SIZE_W:0] sh_c, sh_r;
    logic ge_c, ge_r;
    logic signed [QW-1:0] dc, dr;
    logic signed [QW:0] c_val, r_val;
    logic signed [QW+1:0] cs_s, ce_s, rs_s, re_s, cs_cl, ce_cl, rs_cl, re_cl;
    logic signed [QW+1:0] cols_s, rows_s;
    logic [GDIM_W-1:0] cols_eff, rows_eff;
    logic out_free, in_take;
    logic [CNT_W-1:0] n_lim;

    cgfb_ram #(.WIDTH(CNT_W), .DEPTH(NCELLS), .AW(CELL_AW)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cell_idx),
        .rdata (cnt_rdata)
    );

    cgfb_ram #(.WIDTH(ID_W), .DEPTH(NENT), .AW(ENT_AW)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (id_reg),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != S_IDLE);
    assign in_take       = in_valid && (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found_id      = out_id_reg;
    assign cells_written = out_cw_reg;
    assign last          = out_last_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    assign div_c = (cell_width_reg == '0) ? SIZE_W'(1) : cell_width_reg;
    assign div_r = (cell_height_reg == '0) ? SIZE_W'(1) : cell_height_reg;
    assign sh_c  = {remc_reg, qc_reg[QW-1]};
    assign sh_r  = {remr_reg, qr_reg[QW-1]};
    assign ge_c  = (sh_c >= {1'b0, div_c});
    assign ge_r  = (sh_r >= {1'b0, div_r});

    assign dc = {pos_col[POS_W-1], pos_col} - {origin_col_reg[POS_W-1], origin_col_reg};
    assign dr = {pos_row[POS_W-1], pos_row} - {origin_row_reg[POS_W-1], origin_row_reg};

    assign c_val = neg_c_reg ? -$signed({1'b0, qc_reg}) : $signed({1'b0, qc_reg});
    assign r_val = neg_r_reg ? -$signed({1'b0, qr_reg}) : $signed({1'b0, qr_reg});

    assign cols_eff = (GDIM_W'(grid_cols_reg) > GDIM_W'(MAX_GRID_COLS))
                      ? GDIM_W'(MAX_GRID_COLS) : GDIM_W'(grid_cols_reg);
    assign rows_eff = (GDIM_W'(grid_rows_reg) > GDIM_W'(MAX_GRID_ROWS))
                      ? GDIM_W'(MAX_GRID_ROWS) : GDIM_W'(grid_rows_reg);
    assign cols_s = $signed({{(QW+2-GDIM_W){1'b0}}, cols_eff});
    assign rows_s = $signed({{(QW+2-GDIM_W){1'b0}}, rows_eff});

    assign cs_s  = {c_val[QW], c_val} - $signed({{(QW+2-WIN_W+1){1'b0}}, window_cols_reg[WIN_W-1:1]});
    assign ce_s  = cs_s + $signed({{(QW+2-WIN_W){1'b0}}, window_cols_reg});
    assign rs_s  = {r_val[QW], r_val} - $signed({{(QW+2-WIN_W+1){1'b0}}, window_rows_reg[WIN_W-1:1]});
    assign re_s  = rs_s + $signed({{(QW+2-WIN_W){1'b0}}, window_rows_reg});
    assign cs_cl = (cs_s < 0) ? '0 : cs_s;
    assign rs_cl = (rs_s < 0) ? '0 : rs_s;
    assign ce_cl = (ce_s > cols_s) ? cols_s : ce_s;
    assign re_cl = (re_s > rows_s) ? rows_s : re_s;

    assign cell_idx  = CELL_AW'(32'(i_reg) * 32'(MAX_GRID_COLS) + 32'(j_reg));
    assign ent_raddr = ENT_AW'(32'(cell_idx) * 32'(MAX_PER_CELL) + 32'(k_reg));
    assign ent_waddr = ENT_AW'(32'(cell_idx) * 32'(MAX_PER_CELL) + 32'(cnt_rdata));
    assign n_lim     = (32'(cnt_rdata) > 32'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : cnt_rdata;

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        clr_emit_next   = clr_emit_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        neg_c_next      = neg_c_reg;
        neg_r_next      = neg_r_reg;
        qc_next         = qc_reg;
        qr_next         = qr_reg;
        remc_next       = remc_reg;
        remr_next       = remr_reg;
        div_cnt_next    = div_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cs_next         = cs_reg;
        ce_next         = ce_reg;
        re_next         = re_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        full_next       = full_reg;
        written_next    = written_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_cw_next     = res_cw_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_cw_next     = out_cw_reg;
        out_last_next   = out_last_reg;
        cnt_we          = 1'b0;
        cnt_waddr       = cell_idx;
        cnt_wdata       = CNT_W'(32'(cnt_rdata) + 1);
        ent_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next      = operation;
                    id_next      = feature_id;
                    neg_c_next   = dc[QW-1];
                    neg_r_next   = dr[QW-1];
                    qc_next      = dc[QW-1] ? QW'(-dc) : QW'(dc);
                    qr_next      = dr[QW-1] ? QW'(-dr) : QW'(dr);
                    remc_next    = '0;
                    remr_next    = '0;
                    div_cnt_next = '0;
                    case (operation)
                        OP_INSERT, OP_LOOKUP:
                        begin
                            state_next = S_DIV;
                        end
                        OP_CLEAR:
                        begin
                            sweep_next    = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_reg;
                cnt_wdata = '0;
                if (32'(sweep_reg) == NCELLS - 1)
                begin
                    res_status_next = ST_OK;
                    res_id_next     = '0;
                    res_cw_next     = '0;
                    res_last_next   = 1'b1;
                    state_next      = clr_emit_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + CELL_AW'(1);
                end
            end
            S_DIV:
            begin
                remc_next    = ge_c ? SIZE_W'(sh_c - {1'b0, div_c}) : sh_c[SIZE_W-1:0];
                remr_next    = ge_r ? SIZE_W'(sh_r - {1'b0, div_r}) : sh_r[SIZE_W-1:0];
                qc_next      = {qc_reg[QW-2:0], ge_c};
                qr_next      = {qr_reg[QW-2:0], ge_r};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (32'(div_cnt_reg) == QW - 1)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                res_id_next   = '0;
                res_cw_next   = '0;
                res_last_next = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    full_next    = 1'b0;
                    written_next = '0;
                    if (!window_cols_reg[0] || !window_rows_reg[0])
                    begin
                        res_status_next = ST_EVEN_WIN;
                        state_next      = S_EMIT;
                    end
                    else if ((cs_cl < ce_cl) && (rs_cl < re_cl))
                    begin
                        i_next     = GDIM_W'(rs_cl);
                        j_next     = GDIM_W'(cs_cl);
                        cs_next    = GDIM_W'(cs_cl);
                        ce_next    = GDIM_W'(ce_cl);
                        re_next    = GDIM_W'(re_cl);
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        state_next      = S_EMIT;
                    end
                end
                else
                begin
                    if ((c_val < 0) || (r_val < 0) || ({c_val[QW], c_val} >= cols_s)
                        || ({r_val[QW], r_val} >= rows_s))
                    begin
                        res_status_next = ST_OUTSIDE;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        i_next     = GDIM_W'(r_val);
                        j_next     = GDIM_W'(c_val);
                        state_next = S_LK_ADR;
                    end
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                if (32'(cnt_rdata) >= MAX_PER_CELL)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    cnt_we       = 1'b1;
                    ent_we       = 1'b1;
                    written_next = written_reg + CW_OUT_W'(1);
                end
                state_next = S_INS_RD;
                if (j_reg + GDIM_W'(1) == ce_reg)
                begin
                    j_next = cs_reg;
                    i_next = i_reg + GDIM_W'(1);
                    if (i_reg + GDIM_W'(1) == re_reg)
                    begin
                        res_status_next = (full_next) ? ST_FULL : ST_OK;
                        res_cw_next     = written_next;
                        state_next      = S_EMIT;
                    end
                end
                else
                begin
                    j_next = j_reg + GDIM_W'(1);
                end
            end
            S_LK_ADR:
            begin
                state_next = S_LK_CNT;
            end
            S_LK_CNT:
            begin
                if (cnt_rdata == '0)
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_EMIT;
                end
                else
                begin
                    n_next     = n_lim;
                    k_next     = '0;
                    state_next = S_LK_RD;
                end
            end
            S_LK_RD:
            begin
                state_next = S_LK_DATA;
            end
            S_LK_DATA:
            begin
                res_status_next = ST_OK;
                res_id_next     = ent_rdata;
                res_cw_next     = '0;
                res_last_next   = (32'(k_reg) + 1 == 32'(n_reg));
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_cw_next     = res_cw_reg;
                    out_last_next   = res_last_reg;
                    if (res_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_LK_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            sweep_reg       <= '0;
            clr_emit_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            origin_col_reg  <= '0;
            origin_row_reg  <= '0;
            cell_width_reg  <= SIZE_W'(16);
            cell_height_reg <= SIZE_W'(16);
            window_cols_reg <= WIN_W'(3);
            window_rows_reg <= WIN_W'(3);
            grid_cols_reg   <= GRID_W'(40);
            grid_rows_reg   <= GRID_W'(30);
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            clr_emit_reg  <= clr_emit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ORIGIN_COL:  origin_col_reg  <= cfg_data;
                    REG_ORIGIN_ROW:  origin_row_reg  <= cfg_data;
                    REG_CELL_WIDTH:  cell_width_reg  <= cfg_data[SIZE_W-1:0];
                    REG_CELL_HEIGHT: cell_height_reg <= cfg_data[SIZE_W-1:0];
                    REG_WINDOW_COLS: window_cols_reg <= cfg_data[WIN_W-1:0];
                    REG_WINDOW_ROWS: window_rows_reg <= cfg_data[WIN_W-1:0];
                    REG_GRID_COLS:   grid_cols_reg   <= cfg_data[GRID_W-1:0];
                    REG_GRID_ROWS:   grid_rows_reg   <= cfg_data[GRID_W-1:0];
                    default:         grid_rows_reg   <= grid_rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        neg_c_reg      <= neg_c_next;
        neg_r_reg      <= neg_r_next;
        qc_reg         <= qc_next;
        qr_reg         <= qr_next;
        remc_reg       <= remc_next;
        remr_reg       <= remr_next;
        div_cnt_reg    <= div_cnt_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        cs_reg         <= cs_next;
        ce_reg         <= ce_next;
        re_reg         <= re_next;
        k_reg          <= k_next;
        n_reg          <= n_next;
        full_reg       <= full_next;
        written_reg    <= written_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_cw_reg     <= res_cw_next;
        res_last_reg   <= res_last_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_cw_reg     <= out_cw_next;
        out_last_reg   <= out_last_next;
    end

endmodule

### rtl/cgfb_ram.sv
module cgfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
